@@ sv/cbsf_pkg.sv @@
// Shared types, constants and arithmetic for the cubic Bezier split and fragment block.
package cbsf_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int T_BITS        = FRACTION_BITS + 1;
    localparam int PROD_BITS     = VALUE_BITS + T_BITS + 2;
    localparam int QUOT_BITS     = T_BITS;
    localparam int DEN_BITS      = T_BITS + 1;
    localparam int REM_BITS      = 2 * T_BITS + 1;

    localparam logic [T_BITS-1:0] T_ONE  = T_BITS'(1) << FRACTION_BITS;
    localparam logic [T_BITS-1:0] T_HALF = T_BITS'(1) << (FRACTION_BITS - 1);

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [T_BITS-1:0] tpar_t;
    typedef value_t [3:0] pts_t;

    typedef struct packed {
        logic   op;
        value_t start_value;
        value_t first_control;
        value_t second_control;
        value_t end_value;
        tpar_t  t_low;
        tpar_t  t_high;
    } req_t;

    typedef struct packed {
        value_t seg_start;
        value_t seg_control_a;
        value_t seg_control_b;
        value_t seg_end;
        logic   range_error;
        logic   last;
    } rsp_t;

    typedef struct packed {
        logic  op;
        tpar_t tl;
        tpar_t th;
        pts_t  pts;
    } rec_t;

    typedef struct packed {
        logic  op;
        logic  eq;
        logic  err;
        logic  th_one;
        tpar_t mt;
        pts_t  lo;
        pts_t  hi;
    } side_t;

    function automatic tpar_t sat_t(input tpar_t t);
        return (t > T_ONE) ? T_ONE : t;
    endfunction

    function automatic value_t lerp(input value_t a, input value_t b, input tpar_t t);
        logic signed [VALUE_BITS:0]  d;
        logic signed [PROD_BITS-1:0] p;
        logic signed [PROD_BITS-1:0] r;
        d = $signed({b[VALUE_BITS-1], b}) - $signed({a[VALUE_BITS-1], a});
        p = d * $signed({1'b0, t});
        p = p + $signed(PROD_BITS'(T_HALF));
        r = p >>> FRACTION_BITS;
        return a + r[VALUE_BITS-1:0];
    endfunction

endpackage

@@ sv/cbsf_divider.sv @@
// Pipelined restoring divider that maps the fragment end parameter, one quotient bit per stage.
module cbsf_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  cbsf_pkg::rec_t                      in_rec,
    output logic                                out_valid,
    output cbsf_pkg::rec_t                      out_rec,
    output logic [cbsf_pkg::QUOT_BITS-1:0]      out_quot
);

    logic                               vld_reg  [cbsf_pkg::QUOT_BITS];
    cbsf_pkg::rec_t                     rec_reg  [cbsf_pkg::QUOT_BITS];
    logic [cbsf_pkg::REM_BITS-1:0]      rem_reg  [cbsf_pkg::QUOT_BITS];
    logic [cbsf_pkg::QUOT_BITS-1:0]     quot_reg [cbsf_pkg::QUOT_BITS];

    genvar k;
    generate
        for (k = 0; k < cbsf_pkg::QUOT_BITS; k++)
        begin : g_stage
            logic                           vld_in;
            cbsf_pkg::rec_t                 rec_in;
            logic [cbsf_pkg::REM_BITS-1:0]  rem_in;
            logic [cbsf_pkg::QUOT_BITS-1:0] quot_in;
            logic [cbsf_pkg::T_BITS-1:0]    den;
            logic [cbsf_pkg::REM_BITS-1:0]  divisor;
            logic [cbsf_pkg::REM_BITS:0]    trial;
            logic [cbsf_pkg::REM_BITS-1:0]  rem_next;
            logic [cbsf_pkg::QUOT_BITS-1:0] quot_next;

            if (k == 0)
            begin : g_first
                logic [cbsf_pkg::T_BITS-1:0] diff;
                always_comb
                begin
                    diff    = in_rec.th - in_rec.tl;
                    vld_in  = in_valid;
                    rec_in  = in_rec;
                    rem_in  = {1'b0, diff, {cbsf_pkg::T_BITS{1'b0}}}
                              + cbsf_pkg::REM_BITS'(cbsf_pkg::T_ONE - in_rec.tl);
                    quot_in = '0;
                end
            end
            else
            begin : g_rest
                always_comb
                begin
                    vld_in  = vld_reg[k-1];
                    rec_in  = rec_reg[k-1];
                    rem_in  = rem_reg[k-1];
                    quot_in = quot_reg[k-1];
                end
            end

            always_comb
            begin
                den       = cbsf_pkg::T_ONE - rec_in.tl;
                divisor   = cbsf_pkg::REM_BITS'({den, 1'b0}) << (cbsf_pkg::QUOT_BITS - 1 - k);
                trial     = {1'b0, rem_in} - {1'b0, divisor};
                rem_next  = rem_in;
                quot_next = quot_in;
                if (!trial[cbsf_pkg::REM_BITS])
                begin
                    rem_next = trial[cbsf_pkg::REM_BITS-1:0];
                    quot_next[cbsf_pkg::QUOT_BITS-1-k] = 1'b1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rec_reg[k]  <= rec_in;
                    rem_reg[k]  <= rem_next;
                    quot_reg[k] <= quot_next;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[cbsf_pkg::QUOT_BITS-1];
    assign out_rec   = rec_reg[cbsf_pkg::QUOT_BITS-1];
    assign out_quot  = quot_reg[cbsf_pkg::QUOT_BITS-1];

endmodule

@@ sv/cbsf_split.sv @@
// Three-stage de Casteljau split of one cubic segment at a given parameter.
module cbsf_split (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cbsf_pkg::pts_t    in_pts,
    input  cbsf_pkg::tpar_t   in_t,
    input  cbsf_pkg::side_t   in_side,
    output logic              out_valid,
    output cbsf_pkg::pts_t    out_lo,
    output cbsf_pkg::pts_t    out_hi,
    output cbsf_pkg::side_t   out_side
);

    logic               v1_reg, v2_reg, v3_reg;
    cbsf_pkg::side_t    s1_reg, s2_reg, s3_reg;
    cbsf_pkg::tpar_t    t1_reg, t2_reg;
    cbsf_pkg::value_t   p0_1_reg, p3_1_reg, a_1_reg, b_1_reg, c_1_reg;
    cbsf_pkg::value_t   p0_2_reg, p3_2_reg, a_2_reg, c_2_reg, ab_2_reg, bc_2_reg;
    cbsf_pkg::pts_t     lo_reg, hi_reg;
    cbsf_pkg::value_t   mid;

    assign mid = cbsf_pkg::lerp(ab_2_reg, bc_2_reg, t2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= in_side;
            t1_reg   <= in_t;
            p0_1_reg <= in_pts[0];
            p3_1_reg <= in_pts[3];
            a_1_reg  <= cbsf_pkg::lerp(in_pts[0], in_pts[1], in_t);
            b_1_reg  <= cbsf_pkg::lerp(in_pts[1], in_pts[2], in_t);
            c_1_reg  <= cbsf_pkg::lerp(in_pts[2], in_pts[3], in_t);

            s2_reg   <= s1_reg;
            t2_reg   <= t1_reg;
            p0_2_reg <= p0_1_reg;
            p3_2_reg <= p3_1_reg;
            a_2_reg  <= a_1_reg;
            c_2_reg  <= c_1_reg;
            ab_2_reg <= cbsf_pkg::lerp(a_1_reg, b_1_reg, t1_reg);
            bc_2_reg <= cbsf_pkg::lerp(b_1_reg, c_1_reg, t1_reg);

            s3_reg    <= s2_reg;
            lo_reg[0] <= p0_2_reg;
            lo_reg[1] <= a_2_reg;
            lo_reg[2] <= ab_2_reg;
            lo_reg[3] <= mid;
            hi_reg[0] <= mid;
            hi_reg[1] <= bc_2_reg;
            hi_reg[2] <= c_2_reg;
            hi_reg[3] <= p3_2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_lo    = lo_reg;
    assign out_hi    = hi_reg;
    assign out_side  = s3_reg;

endmodule

@@ sv/cubic_bezier_split_and_fragment.sv @@
// Top level of the cubic Bezier split and fragment pipeline.
// A transaction on req passes an input register, a 17-stage divider, two 3-stage
// de Casteljau splitters and an output register. The pipeline takes one transaction
// per cycle while it is not held; a split yields two results over the single result
// channel, one after the other, and holds the pipeline while the second one waits,
// while every fragment yields one. The whole pipeline holds when rsp stalls.
module cubic_bezier_split_and_fragment (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  cbsf_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output cbsf_pkg::rsp_t  rsp
);

    logic               adv;
    logic               a_valid_reg;
    cbsf_pkg::rec_t     a_rec_reg;
    cbsf_pkg::rec_t     a_rec_next;

    logic               d_valid;
    cbsf_pkg::rec_t     d_rec;
    logic [cbsf_pkg::QUOT_BITS-1:0] d_quot;
    cbsf_pkg::side_t    side1;

    logic               s1_valid;
    cbsf_pkg::pts_t     s1_lo, s1_hi;
    cbsf_pkg::side_t    s1_side;
    cbsf_pkg::side_t    side2;

    logic               s2_valid;
    cbsf_pkg::pts_t     s2_lo, s2_hi;
    cbsf_pkg::side_t    s2_side;

    cbsf_pkg::rsp_t     r0, r1;
    logic               two;

    logic               out_valid_reg;
    logic               pend_reg;
    cbsf_pkg::rsp_t     out_reg;
    cbsf_pkg::rsp_t     second_reg;

    assign adv       = !out_valid_reg || (rsp_ready && !pend_reg);
    assign req_ready = adv;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        a_rec_next.op     = req.op;
        a_rec_next.tl     = cbsf_pkg::sat_t(req.t_low);
        a_rec_next.th     = cbsf_pkg::sat_t(req.t_high);
        a_rec_next.pts[0] = req.start_value;
        a_rec_next.pts[1] = req.first_control;
        a_rec_next.pts[2] = req.second_control;
        a_rec_next.pts[3] = req.end_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_rec_reg <= a_rec_next;
        end
    end

    cbsf_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (a_valid_reg),
        .in_rec    (a_rec_reg),
        .out_valid (d_valid),
        .out_rec   (d_rec),
        .out_quot  (d_quot)
    );

    always_comb
    begin
        side1.op     = d_rec.op;
        side1.eq     = (d_rec.tl == d_rec.th);
        side1.err    = (d_rec.tl > d_rec.th);
        side1.th_one = (d_rec.th == cbsf_pkg::T_ONE);
        side1.mt     = (d_quot > cbsf_pkg::T_ONE) ? cbsf_pkg::T_ONE : d_quot;
        side1.lo     = '0;
        side1.hi     = '0;
    end

    cbsf_split u_split_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_valid),
        .in_pts    (d_rec.pts),
        .in_t      (d_rec.tl),
        .in_side   (side1),
        .out_valid (s1_valid),
        .out_lo    (s1_lo),
        .out_hi    (s1_hi),
        .out_side  (s1_side)
    );

    always_comb
    begin
        side2    = s1_side;
        side2.lo = s1_lo;
        side2.hi = s1_hi;
    end

    cbsf_split u_split_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s1_valid),
        .in_pts    (s1_hi),
        .in_t      (s1_side.mt),
        .in_side   (side2),
        .out_valid (s2_valid),
        .out_lo    (s2_lo),
        .out_hi    (s2_hi),
        .out_side  (s2_side)
    );

    always_comb
    begin
        two              = 1'b0;
        r0               = '0;
        r1               = '0;
        r0.last          = 1'b1;
        r1.last          = 1'b1;
        if (!s2_side.op)
        begin
            two              = 1'b1;
            r0.seg_start     = s2_side.lo[0];
            r0.seg_control_a = s2_side.lo[1];
            r0.seg_control_b = s2_side.lo[2];
            r0.seg_end       = s2_side.lo[3];
            r0.last          = 1'b0;
            r1.seg_start     = s2_side.hi[0];
            r1.seg_control_a = s2_side.hi[1];
            r1.seg_control_b = s2_side.hi[2];
            r1.seg_end       = s2_side.hi[3];
        end
        else if (s2_side.eq)
        begin
            r0.seg_start     = s2_side.lo[3];
            r0.seg_control_a = s2_side.lo[3];
            r0.seg_control_b = s2_side.lo[3];
            r0.seg_end       = s2_side.lo[3];
        end
        else if (s2_side.err)
        begin
            r0.range_error   = 1'b1;
        end
        else if (s2_side.th_one)
        begin
            r0.seg_start     = s2_side.hi[0];
            r0.seg_control_a = s2_side.hi[1];
            r0.seg_control_b = s2_side.hi[2];
            r0.seg_end       = s2_side.hi[3];
        end
        else
        begin
            r0.seg_start     = s2_lo[0];
            r0.seg_control_a = s2_lo[1];
            r0.seg_control_b = s2_lo[2];
            r0.seg_end       = s2_lo[3];
        end
        if (s2_hi[0] != s2_lo[3])
        begin
            two = two;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s2_valid;
            pend_reg      <= s2_valid && two;
        end
        else if (rsp_ready)
        begin
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg    <= r0;
            second_reg <= r1;
        end
        else if (rsp_ready && pend_reg)
        begin
            out_reg <= second_reg;
        end
    end

endmodule
